// ===== src/assert_macros.svh =====
// Assertion macros for the handle table RTL.
// Depends on: a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/rht_pkg.sv =====
// Shared types and codes for the reference counting handle table.
// Depends on: nothing.
`default_nettype none

package rht_pkg;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 80;
    localparam int COUNT_W   = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    localparam logic [3:0] CMD_ALLOC   = 4'd0;
    localparam logic [3:0] CMD_CLONE   = 4'd1;
    localparam logic [3:0] CMD_READ    = 4'd2;
    localparam logic [3:0] CMD_PUSH    = 4'd3;
    localparam logic [3:0] CMD_POP     = 4'd4;
    localparam logic [3:0] CMD_PEEK    = 4'd5;
    localparam logic [3:0] CMD_FRAME   = 4'd6;
    localparam logic [3:0] CMD_RETRACT = 4'd7;
    localparam logic [3:0] CMD_SWEEP   = 4'd8;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_VACANT  = 3'd1;
    localparam logic [2:0] ST_STACK_FULL = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_FRAME_FULL = 3'd4;
    localparam logic [2:0] ST_FREED      = 3'd5;
    localparam logic [2:0] ST_BEYOND     = 3'd6;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd7;

    localparam logic [1:0] HS_ZERO = 2'd0;
    localparam logic [1:0] HS_ENT  = 2'd1;
    localparam logic [1:0] HS_IDX  = 2'd2;
    localparam logic [1:0] HS_KEEP = 2'd3;

    typedef struct packed {
        logic       load;
        logic       res_set;
        logic [2:0] res_st;
        logic [1:0] res_h;
        logic       res_show;
        logic       idx_clr;
        logic       idx_inc;
        logic       wrd_rd_ent;
        logic       clone_take;
        logic       alloc_wr;
        logic       cnt_rd_ent;
        logic       push_wr;
        logic       root_rd_top;
        logic       root_rd_peek;
        logic       h_take;
        logic       drop_wr;
        logic       frame_wr;
        logic       frame_rd;
        logic       trail_zero;
        logic       trail_take;
        logic       sweep;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic       e_live;
        logic       stack_full;
        logic       stack_empty;
        logic       peek_bad;
        logic       frame_full;
        logic       frame_empty;
        logic       idx_vacant;
        logic       idx_last;
        logic       trail_above;
        logic       at_trail;
        logic       out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/rht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on: nothing.
`default_nettype none

module rht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/rht_ctrl.sv =====
// Command sequencer of the handle table: one item at a time through its steps.
// Depends on: rht_pkg (command, status and handle codes, dp_cmd_t, dp_stat_t).
`default_nettype none

module rht_ctrl import rht_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DEC  = 5'd1;
    localparam logic [4:0] S_CLN  = 5'd2;
    localparam logic [4:0] S_SRCH = 5'd3;
    localparam logic [4:0] S_ALW  = 5'd4;
    localparam logic [4:0] S_PSHW = 5'd5;
    localparam logic [4:0] S_POPH = 5'd6;
    localparam logic [4:0] S_POPC = 5'd7;
    localparam logic [4:0] S_POPD = 5'd8;
    localparam logic [4:0] S_PKH  = 5'd9;
    localparam logic [4:0] S_FRT  = 5'd10;
    localparam logic [4:0] S_RCHK = 5'd11;
    localparam logic [4:0] S_RLP  = 5'd12;
    localparam logic [4:0] S_RH   = 5'd13;
    localparam logic [4:0] S_RC   = 5'd14;
    localparam logic [4:0] S_RD   = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    function automatic dp_cmd_t res(dp_cmd_t c, logic [2:0] st, logic [1:0] hs, logic show);
        dp_cmd_t r;
        r          = c;
        r.res_set  = 1'b1;
        r.res_st   = st;
        r.res_h    = hs;
        r.res_show = show;
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_FIN;
                unique case (stat.cmd)
                    CMD_ALLOC:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_SRCH;
                    end
                    CMD_CLONE:
                    begin
                        if (!stat.e_live)
                        begin
                            cmd = res(cmd, ST_FREED, HS_ENT, 1'b0);
                        end
                        else
                        begin
                            cmd.wrd_rd_ent = 1'b1;
                            state_next     = S_CLN;
                        end
                    end
                    CMD_READ:
                    begin
                        cmd = res(cmd, stat.e_live ? ST_OK : ST_FREED, HS_ENT, 1'b1);
                    end
                    CMD_PUSH:
                    begin
                        if (!stat.e_live)
                        begin
                            cmd = res(cmd, ST_FREED, HS_ENT, 1'b0);
                        end
                        else if (stat.stack_full)
                        begin
                            cmd = res(cmd, ST_STACK_FULL, HS_ENT, 1'b1);
                        end
                        else
                        begin
                            cmd.cnt_rd_ent = 1'b1;
                            state_next     = S_PSHW;
                        end
                    end
                    CMD_POP:
                    begin
                        if (stat.stack_empty)
                        begin
                            cmd = res(cmd, ST_EMPTY, HS_ZERO, 1'b0);
                        end
                        else
                        begin
                            cmd.root_rd_top = 1'b1;
                            state_next      = S_POPH;
                        end
                    end
                    CMD_PEEK:
                    begin
                        if (stat.stack_empty)
                        begin
                            cmd = res(cmd, ST_EMPTY, HS_ZERO, 1'b0);
                        end
                        else if (stat.peek_bad)
                        begin
                            cmd = res(cmd, ST_BAD_OFFSET, HS_ZERO, 1'b0);
                        end
                        else
                        begin
                            cmd.root_rd_peek = 1'b1;
                            state_next       = S_PKH;
                        end
                    end
                    CMD_FRAME:
                    begin
                        if (stat.frame_full)
                        begin
                            cmd = res(cmd, ST_FRAME_FULL, HS_ZERO, 1'b0);
                        end
                        else
                        begin
                            cmd.frame_wr = 1'b1;
                            cmd          = res(cmd, ST_OK, HS_ZERO, 1'b0);
                        end
                    end
                    CMD_RETRACT:
                    begin
                        if (stat.frame_empty)
                        begin
                            cmd.trail_zero = 1'b1;
                            state_next     = S_RCHK;
                        end
                        else
                        begin
                            cmd.frame_rd = 1'b1;
                            state_next   = S_FRT;
                        end
                    end
                    CMD_SWEEP:
                    begin
                        cmd.sweep = 1'b1;
                        cmd       = res(cmd, ST_OK, HS_ZERO, 1'b0);
                    end
                    default:
                    begin
                        cmd = res(cmd, ST_OK, HS_ZERO, 1'b0);
                    end
                endcase
            end
            S_CLN:
            begin
                cmd.clone_take = 1'b1;
                cmd.idx_clr    = 1'b1;
                state_next     = S_SRCH;
            end
            S_SRCH:
            begin
                priority if (stat.idx_vacant)
                begin
                    state_next = S_ALW;
                end
                else if (stat.idx_last)
                begin
                    cmd        = res(cmd, ST_NO_VACANT, HS_ZERO, 1'b0);
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_ALW:
            begin
                cmd.alloc_wr = 1'b1;
                cmd          = res(cmd, ST_OK, HS_IDX, 1'b1);
                state_next   = S_FIN;
            end
            S_PSHW:
            begin
                cmd.push_wr = 1'b1;
                cmd         = res(cmd, ST_OK, HS_ENT, 1'b1);
                state_next  = S_FIN;
            end
            S_POPH:
            begin
                cmd.h_take = 1'b1;
                state_next = S_POPC;
            end
            S_POPC:
            begin
                state_next = S_POPD;
            end
            S_POPD:
            begin
                cmd.drop_wr = 1'b1;
                cmd         = res(cmd, ST_OK, HS_KEEP, 1'b1);
                state_next  = S_FIN;
            end
            S_PKH:
            begin
                cmd.h_take = 1'b1;
                cmd        = res(cmd, ST_OK, HS_KEEP, 1'b1);
                state_next = S_FIN;
            end
            S_FRT:
            begin
                cmd.trail_take = 1'b1;
                state_next     = S_RCHK;
            end
            S_RCHK:
            begin
                if (stat.trail_above)
                begin
                    cmd        = res(cmd, ST_BEYOND, HS_ZERO, 1'b0);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RLP;
                end
            end
            S_RLP:
            begin
                if (stat.at_trail)
                begin
                    cmd        = res(cmd, ST_OK, HS_ZERO, 1'b0);
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.root_rd_top = 1'b1;
                    state_next      = S_RH;
                end
            end
            S_RH:
            begin
                cmd.h_take = 1'b1;
                state_next = S_RC;
            end
            S_RC:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.drop_wr = 1'b1;
                state_next  = S_RLP;
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/rht_dp.sv =====
// Datapath of the handle table: item registers, entry, count, root and frame
// memories, live and nonzero-count bits, result register.
// Depends on: rht_pkg, rht_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rht_dp import rht_pkg::*; #(
    parameter int ENTRIES     = 256,
    parameter int STACK_DEPTH = 256,
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tuser,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat
);

    localparam int HLIM = (ENTRIES < 256) ? ENTRIES : 256;
    localparam int IW   = $clog2(HLIM);
    localparam int TW   = $clog2(STACK_DEPTH + 1);
    localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW   = $clog2(FRAME_DEPTH + 1);
    localparam int FAW  = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int PW   = (TW > 8) ? TW : 8;

    logic [3:0]          cmd_reg;
    logic                kind_reg;
    logic signed [63:0]  val_reg;
    logic [7:0]          ent_reg;
    logic [7:0]          off_reg;
    logic [2:0]          st_reg;
    logic [7:0]          h_reg;
    logic                show_reg;
    logic [IW-1:0]       idx_reg;
    logic [TW-1:0]       root_top_reg;
    logic [FW-1:0]       frame_top_reg;
    logic [TW-1:0]       trail_reg;
    logic [HLIM-1:0]     live_reg;
    logic [HLIM-1:0]     live_next;
    logic [HLIM-1:0]     nz_reg;
    logic [HLIM-1:0]     nz_next;
    logic                out_valid_reg;
    logic [2:0]          out_status_reg;
    logic [7:0]          out_handle_reg;
    logic signed [63:0]  out_data_reg;
    logic                out_kind_reg;

    logic [IW-1:0]       e_idx;
    logic [IW-1:0]       h_idx;
    logic                h_in;
    logic [64:0]         wrd_rdata;
    logic [COUNT_W-1:0]  cnt_rdata;
    logic [COUNT_W-1:0]  cnt_cur;
    logic [COUNT_W-1:0]  cnt_inc;
    logic                cnt_we;
    logic [IW-1:0]       cnt_waddr;
    logic [COUNT_W-1:0]  cnt_wdata;
    logic [7:0]          root_rdata;
    logic [SAW-1:0]      root_raddr;
    logic [PW-1:0]       peek_pos;
    logic [TW-1:0]       frame_rdata;

    assign e_idx = ent_reg[IW-1:0];
    assign h_idx = h_reg[IW-1:0];
    assign h_in  = ({1'b0, h_reg} < 9'(HLIM));

    // Unpack the slave transfer: command, value, entry, offset from the lowest bit up.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= s_tdata[3:0];
            kind_reg <= s_tuser;
            val_reg  <= s_tdata[67:4];
            ent_reg  <= s_tdata[75:68];
            off_reg  <= s_tdata[83:76];
        end
        else if (cmd.clone_take)
        begin
            val_reg  <= wrd_rdata[63:0];
            kind_reg <= wrd_rdata[64];
        end
        if (cmd.res_set)
        begin
            st_reg   <= cmd.res_st;
            show_reg <= cmd.res_show;
        end
        if (cmd.h_take)
        begin
            h_reg <= root_rdata;
        end
        else if (cmd.res_set)
        begin
            unique case (cmd.res_h)
                HS_ZERO: h_reg <= '0;
                HS_ENT:  h_reg <= ent_reg;
                HS_IDX:  h_reg <= 8'(idx_reg);
                HS_KEEP: h_reg <= h_reg;
                default: h_reg <= h_reg;
            endcase
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.trail_zero)
        begin
            trail_reg <= '0;
        end
        else if (cmd.trail_take)
        begin
            trail_reg <= frame_rdata;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= st_reg;
            out_handle_reg <= h_reg;
            out_data_reg   <= (show_reg && h_in && live_reg[h_idx]) ? wrd_rdata[63:0] : '0;
            out_kind_reg   <= show_reg && h_in && live_reg[h_idx] && wrd_rdata[64];
        end
    end

    always_comb
    begin
        live_next = live_reg;
        nz_next   = nz_reg;
        if (cmd.alloc_wr)
        begin
            live_next[idx_reg] = 1'b1;
            nz_next[idx_reg]   = 1'b0;
        end
        if (cmd.push_wr)
        begin
            nz_next[e_idx] = 1'b1;
        end
        if (cmd.drop_wr && nz_reg[h_idx] && (cnt_rdata == COUNT_W'(1)))
        begin
            nz_next[h_idx] = 1'b0;
        end
        if (cmd.sweep)
        begin
            live_next = live_reg & nz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= '0;
            nz_reg        <= '0;
            root_top_reg  <= '0;
            frame_top_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            nz_reg   <= nz_next;
            if (cmd.push_wr)
            begin
                root_top_reg <= root_top_reg + 1'b1;
            end
            else if (cmd.root_rd_top)
            begin
                root_top_reg <= root_top_reg - 1'b1;
            end
            if (cmd.frame_wr)
            begin
                frame_top_reg <= frame_top_reg + 1'b1;
            end
            else if (cmd.frame_rd)
            begin
                frame_top_reg <= frame_top_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cnt_cur   = nz_reg[e_idx] ? cnt_rdata : '0;
    assign cnt_inc   = (cnt_cur == COUNT_MAX) ? COUNT_MAX : cnt_cur + 1'b1;
    assign cnt_we    = cmd.push_wr || (cmd.drop_wr && nz_reg[h_idx]);
    assign cnt_waddr = cmd.push_wr ? e_idx : h_idx;
    assign cnt_wdata = cmd.push_wr ? cnt_inc : cnt_rdata - 1'b1;

    assign peek_pos   = PW'(root_top_reg) - PW'(off_reg) - 1'b1;
    assign root_raddr = cmd.root_rd_peek ? peek_pos[SAW-1:0] : SAW'(root_top_reg - 1'b1);

    rht_ram #(.WIDTH(65), .DEPTH(HLIM)) u_word_ram (
        .clk   (clk),
        .we    (cmd.alloc_wr),
        .waddr (idx_reg),
        .wdata ({kind_reg, val_reg}),
        .raddr (cmd.wrd_rd_ent ? e_idx : h_idx),
        .rdata (wrd_rdata)
    );

    rht_ram #(.WIDTH(COUNT_W), .DEPTH(HLIM)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cmd.cnt_rd_ent ? e_idx : h_idx),
        .rdata (cnt_rdata)
    );

    rht_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_root_ram (
        .clk   (clk),
        .we    (cmd.push_wr),
        .waddr (root_top_reg[SAW-1:0]),
        .wdata (ent_reg),
        .raddr (root_raddr),
        .rdata (root_rdata)
    );

    rht_ram #(.WIDTH(TW), .DEPTH(FRAME_DEPTH)) u_frame_ram (
        .clk   (clk),
        .we    (cmd.frame_wr),
        .waddr (frame_top_reg[FAW-1:0]),
        .wdata (root_top_reg),
        .raddr (FAW'(frame_top_reg - 1'b1)),
        .rdata (frame_rdata)
    );

    assign stat.cmd         = cmd_reg;
    assign stat.e_live      = ({1'b0, ent_reg} < 9'(HLIM)) && live_reg[e_idx];
    assign stat.stack_full  = (root_top_reg >= TW'(STACK_DEPTH));
    assign stat.stack_empty = (root_top_reg == '0);
    assign stat.peek_bad    = (PW'(off_reg) >= PW'(root_top_reg));
    assign stat.frame_full  = (frame_top_reg >= FW'(FRAME_DEPTH));
    assign stat.frame_empty = (frame_top_reg == '0);
    assign stat.idx_vacant  = !nz_reg[idx_reg];
    assign stat.idx_last    = (idx_reg == IW'(HLIM - 1));
    assign stat.trail_above = (trail_reg > root_top_reg);
    assign stat.at_trail    = (root_top_reg == trail_reg);
    assign stat.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg, out_handle_reg, out_status_reg};
    assign m_tuser  = out_kind_reg;

    `ASSERT_ALWAYS(a_root_bound, root_top_reg <= TW'(STACK_DEPTH), "root stack height overrun")
    `ASSERT_ALWAYS(a_frame_bound, frame_top_reg <= FW'(FRAME_DEPTH), "frame stack height overrun")
    `ASSERT_ALWAYS(a_push_room, !cmd.push_wr || !stat.stack_full, "push on a full root stack")
    `ASSERT_NEXT(a_out_hold, out_valid_reg && !m_tready && !cmd.out_load,
        out_valid_reg && $stable(out_handle_reg), "result dropped while stalled")

endmodule

`default_nettype wire

// ===== src/refcount_handle_table_unit.sv =====
// Reference counting handle table with a root stack and frame marks.
// Depends on: rht_pkg, rht_ctrl, rht_dp.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one command per
//   transfer; master channel (m_tvalid/m_tready/m_tdata/m_tuser) returns one
//   result per command, in order.
//   One command is worked at a time. Alloc searches the count bits linearly
//   for the lowest vacant index; clone reads the source word first and then
//   searches the same way. Retract unwinds the roots one at a time, with a
//   read-then-write sequence on the count memory for each dropped
//   reference; it unwinds to the bottom of the stack with no frame mark, and
//   it stops without unwinding when the mark lies above the stack height.
//   s_tready is high while no command is in progress; the result register
//   lets a new command start while the previous result waits.
//   A stalled m_tready holds the result; the next finished command waits
//   behind it.
//   Reset clears live and nonzero-count bits, root and frame heights; no clearing pass.
`default_nettype none

module refcount_handle_table_unit import rht_pkg::*; #(
    parameter int ENTRIES     = 256,
    parameter int STACK_DEPTH = 256,
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // command[3:0], value[67:4], entry[75:68], offset[83:76], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[2:0], handle[10:3], data[74:11], zero fill
    output logic      [M_TDATA_W-1:0] m_tdata,
    // data_kind[0]
    output logic                      m_tuser
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rht_dp #(
        .ENTRIES     (ENTRIES),
        .STACK_DEPTH (STACK_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for refcount_handle_table_unit: random and directed commands
// on the stream input, results checked against an in-bench table and stack model.
// Depends on: rht_pkg and refcount_handle_table_unit.
`timescale 1ns / 100ps

module tb_top;
    import rht_pkg::*;

    localparam int NUM_ENT    = 256;
    localparam int ROOT_DEPTH = 256;
    localparam int MARK_DEPTH = 64;
    localparam int IDLE_LIMIT = 6000;
    localparam int RAND_ITEMS = 1500;

    typedef struct {
        logic [3:0]  op;
        logic        kind;
        logic [63:0] value;
        logic [7:0]  ent;
        logic [7:0]  offs;
        bit          drain;
    } command_t;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  handle;
        logic [63:0] data;
        logic        dkind;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    refcount_handle_table_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [63:0] tbl_word [NUM_ENT];
    logic        tbl_str [NUM_ENT];
    logic        tbl_live [NUM_ENT];
    logic [8:0]  tbl_count [NUM_ENT];
    logic [7:0]  roots [ROOT_DEPTH];
    int          root_height = 0;
    int          marks [MARK_DEPTH];
    int          mark_height = 0;

    command_t stim_q[$];
    outcome_t expected_q[$];
    command_t cur;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_drains = 0;
    int errors = 0;
    int idle_cycles = 0;
    bit long_hold_done = 0;
    logic [7:0] status_seen = '0;

    initial
    begin
        for (int i = 0; i < NUM_ENT; i++)
        begin
            tbl_live[i] = 1'b0;
            tbl_count[i] = '0;
        end
    end

    function automatic outcome_t show_entry(logic [2:0] st, logic [7:0] h);
        outcome_t r;
        r.status = st;
        r.handle = h;
        r.data = tbl_live[h] ? tbl_word[h] : 64'd0;
        r.dkind = tbl_live[h] ? tbl_str[h] : 1'b0;
        return r;
    endfunction

    function automatic void drop_count(logic [7:0] h);
        if (tbl_count[h] != 0)
            tbl_count[h] = tbl_count[h] - 1'b1;
    endfunction

    function automatic outcome_t apply_command(command_t c);
        outcome_t r;
        int vacant;
        int trail;
        logic [63:0] w;
        logic k;
        r = '{default: '0};
        vacant = -1;
        case (c.op)
            CMD_ALLOC, CMD_CLONE:
            begin
                if (c.op == CMD_CLONE && !tbl_live[c.ent])
                begin
                    r.status = ST_FREED;
                    r.handle = c.ent;
                end
                else
                begin
                    w = (c.op == CMD_CLONE) ? tbl_word[c.ent] : c.value;
                    k = (c.op == CMD_CLONE) ? tbl_str[c.ent] : c.kind;
                    for (int i = 0; i < NUM_ENT; i++)
                        if (vacant < 0 && tbl_count[i] == 0)
                            vacant = i;
                    if (vacant < 0)
                        r.status = ST_NO_VACANT;
                    else
                    begin
                        tbl_word[vacant] = w;
                        tbl_str[vacant] = k;
                        tbl_live[vacant] = 1'b1;
                        tbl_count[vacant] = '0;
                        r = show_entry(ST_OK, vacant[7:0]);
                    end
                end
            end
            CMD_READ:
                r = show_entry(tbl_live[c.ent] ? ST_OK : ST_FREED, c.ent);
            CMD_PUSH:
            begin
                if (!tbl_live[c.ent])
                begin
                    r.status = ST_FREED;
                    r.handle = c.ent;
                end
                else if (root_height >= ROOT_DEPTH)
                    r = show_entry(ST_STACK_FULL, c.ent);
                else
                begin
                    if (tbl_count[c.ent] < COUNT_MAX)
                        tbl_count[c.ent] = tbl_count[c.ent] + 1'b1;
                    roots[root_height] = c.ent;
                    root_height++;
                    r = show_entry(ST_OK, c.ent);
                end
            end
            CMD_POP:
            begin
                if (root_height == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    root_height--;
                    drop_count(roots[root_height]);
                    r = show_entry(ST_OK, roots[root_height]);
                end
            end
            CMD_PEEK:
            begin
                if (root_height == 0)
                    r.status = ST_EMPTY;
                else if (int'(c.offs) >= root_height)
                    r.status = ST_BAD_OFFSET;
                else
                    r = show_entry(ST_OK, roots[root_height - 1 - int'(c.offs)]);
            end
            CMD_FRAME:
            begin
                if (mark_height >= MARK_DEPTH)
                    r.status = ST_FRAME_FULL;
                else
                begin
                    marks[mark_height] = root_height;
                    mark_height++;
                end
            end
            CMD_RETRACT:
            begin
                trail = 0;
                if (mark_height > 0)
                begin
                    mark_height--;
                    trail = marks[mark_height];
                end
                if (trail > root_height)
                    r.status = ST_BEYOND;
                else
                begin
                    for (int i = trail; i < root_height; i++)
                        drop_count(roots[i]);
                    root_height = trail;
                end
            end
            CMD_SWEEP:
                for (int i = 0; i < NUM_ENT; i++)
                    if (tbl_count[i] == 0)
                        tbl_live[i] = 1'b0;
            default:
                r = '{default: '0};
        endcase
        return r;
    endfunction

    function automatic command_t mk(logic [3:0] op, logic kind, logic [63:0] value,
                                    logic [7:0] ent, logic [7:0] offs);
        command_t c;
        c.op = op;
        c.kind = kind;
        c.value = value;
        c.ent = ent;
        c.offs = offs;
        c.drain = 0;
        return c;
    endfunction

    function automatic command_t rand_item();
        int pick;
        logic [3:0] op;
        logic [7:0] ent;
        logic [7:0] offs;
        pick = $urandom_range(0, 99);
        if (pick < 20) op = CMD_ALLOC;
        else if (pick < 27) op = CMD_CLONE;
        else if (pick < 35) op = CMD_READ;
        else if (pick < 55) op = CMD_PUSH;
        else if (pick < 70) op = CMD_POP;
        else if (pick < 80) op = CMD_PEEK;
        else if (pick < 87) op = CMD_FRAME;
        else if (pick < 93) op = CMD_RETRACT;
        else if (pick < 97) op = CMD_SWEEP;
        else op = 4'($urandom_range(9, 15));
        ent = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
        offs = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        return mk(op, 1'($urandom), {$urandom, $urandom}, ent, offs);
    endfunction

    function automatic command_t drain_mark();
        command_t c;
        c = mk(CMD_SWEEP, 0, 0, 0, 0);
        c.drain = 1;
        return c;
    endfunction

    initial
    begin
        stim_q.push_back(mk(CMD_READ, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_POP, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_PEEK, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_RETRACT, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_ALLOC, 0, 64'h8000_0000_0000_0000, 0, 0));
        stim_q.push_back(mk(CMD_ALLOC, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0));
        stim_q.push_back(mk(CMD_ALLOC, 1, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF));
        stim_q.push_back(mk(CMD_CLONE, 0, 0, 1, 0));
        stim_q.push_back(mk(CMD_CLONE, 0, 0, 8'hFF, 0));
        stim_q.push_back(mk(CMD_PUSH, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_PUSH, 0, 0, 1, 0));
        stim_q.push_back(mk(CMD_PUSH, 0, 0, 8'hFF, 0));
        stim_q.push_back(mk(CMD_PEEK, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_PEEK, 0, 0, 0, 1));
        stim_q.push_back(mk(CMD_PEEK, 0, 0, 0, 8'hFF));
        stim_q.push_back(mk(CMD_READ, 0, 0, 1, 0));
        stim_q.push_back(mk(CMD_FRAME, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_POP, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_POP, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_RETRACT, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_SWEEP, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_READ, 0, 0, 0, 0));
        stim_q.push_back(mk(4'd9, 1, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF));
        stim_q.push_back(mk(4'd15, 0, 0, 0, 0));
        stim_q.push_back(drain_mark());
        // overflow the frame stack, then unwind every mark
        for (int i = 0; i < MARK_DEPTH + 2; i++)
            stim_q.push_back(mk(CMD_FRAME, 0, 0, 0, 0));
        for (int i = 0; i < MARK_DEPTH + 2; i++)
            stim_q.push_back(mk(CMD_RETRACT, 0, 0, 0, 0));
        // fill the table and the root stack
        for (int i = 0; i < NUM_ENT; i++)
        begin
            stim_q.push_back(mk(CMD_ALLOC, 1'($urandom), {$urandom, $urandom}, 0, 0));
            stim_q.push_back(mk(CMD_PUSH, 0, 0, 8'(i), 0));
        end
        stim_q.push_back(mk(CMD_ALLOC, 0, 64'd5, 0, 0));
        stim_q.push_back(mk(CMD_CLONE, 0, 0, 8'd7, 0));
        stim_q.push_back(mk(CMD_PUSH, 0, 0, 8'd9, 0));
        stim_q.push_back(mk(CMD_PEEK, 0, 0, 0, 8'hFF));
        stim_q.push_back(drain_mark());
        stim_q.push_back(mk(CMD_RETRACT, 0, 0, 0, 0));
        stim_q.push_back(mk(CMD_SWEEP, 0, 0, 0, 0));
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            stim_q.push_back(rand_item());
            if ($urandom_range(0, 199) == 0)
                stim_q.push_back(drain_mark());
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (stim_q.size() != 0 || expected_q.size() != 0 || s_tvalid);
        repeat (50) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $error("results missing: %0d", expected_q.size());
            errors++;
        end
        $display("Run covered %0d commands, %0d results, %0d drain pauses.",
                 n_sent, n_results, n_drains);
        $display("Status codes seen (bit per code): %b", status_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_q.push_back(apply_command(cur));
                n_sent++;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the offered transfer
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (stim_q.size() != 0 && stim_q[0].drain)
            begin
                s_tvalid <= 1'b0;
                if (expected_q.size() == 0)
                begin
                    void'(stim_q.pop_front());
                    n_drains++;
                end
            end
            else if (stim_q.size() != 0)
            begin
                cur = stim_q.pop_front();
                s_tdata <= {4'b0, cur.offs, cur.ent, cur.value, cur.op};
                s_tuser <= cur.kind;
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        logic [2:0] got_status;
        logic [7:0] got_handle;
        logic [63:0] got_data;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_status = m_tdata[2:0];
                got_handle = m_tdata[10:3];
                got_data = m_tdata[74:11];
                n_results++;
                status_seen[got_status] = 1'b1;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: status %0d handle %0d", got_status, got_handle);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got_status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got_status);
                        errors++;
                    end
                    if (got_handle !== want.handle)
                    begin
                        $error("handle: expected %0d, actual %0d", want.handle, got_handle);
                        errors++;
                    end
                    if (got_data !== want.data)
                    begin
                        $error("data: expected %h, actual %h", want.data, got_data);
                        errors++;
                    end
                    if (m_tuser !== want.dkind)
                    begin
                        $error("data_kind: expected %0d, actual %0d", want.dkind, m_tuser);
                        errors++;
                    end
                end
            end
            if (!long_hold_done && n_results == 300)
            begin
                long_hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if ((n_results / 250) % 2 == 1)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transfer", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
+incdir+src
src/rht_pkg.sv
src/rht_ram.sv
src/rht_ctrl.sv
src/rht_dp.sv
src/refcount_handle_table_unit.sv
tb/sv/tb_top.sv
